[src/gbp_pkg.sv]
`timescale 1ns / 1ps

package gbp_pkg;

    localparam int PC_W             = 32;
    // Word address: the PC without its two byte-offset bits.
    localparam int WORD_W           = PC_W - 2;
    localparam int DEF_BTB_ENTRIES  = 64;
    localparam int DEF_HISTORY_BITS = 10;
    localparam int QUEUE_DEPTH      = 2;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    // Layout of one queued item; the buffer index sits on top of the fixed fields.
    localparam int ITEM_KIND    = 0;
    localparam int ITEM_TAKEN   = 1;
    localparam int ITEM_PC_LSB  = 2;
    localparam int ITEM_TGT_LSB = ITEM_PC_LSB + PC_W;
    localparam int ITEM_BI_LSB  = ITEM_TGT_LSB + PC_W;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    localparam logic [1:0] CTR_MIN        = 2'd0;
    localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [1:0] CTR_MAX        = 2'd3;

    localparam logic [PC_W-1:0] PC_STEP = 32'd4;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_REM,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_EXEC
    } back_state_t;

endpackage

[src/gbp_queue.sv]
`timescale 1ns / 1ps

module gbp_queue #(
    parameter int WIDTH = 68
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int DEPTH = gbp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[src/gbp_front.sv]
`timescale 1ns / 1ps

module gbp_front #(
    parameter int BTB_ENTRIES = gbp_pkg::DEF_BTB_ENTRIES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                busy,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_tuser,
    input  logic [gbp_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                q_valid,
    input  logic                                q_ready,
    output logic [gbp_pkg::ITEM_BI_LSB+$clog2(BTB_ENTRIES)-1:0] q_data
);

    localparam int BI_W    = $clog2(BTB_ENTRIES);
    localparam int BASE_W  = gbp_pkg::ITEM_BI_LSB;
    localparam bit IS_POW2 = ((BTB_ENTRIES & (BTB_ENTRIES - 1)) == 0);

    logic [gbp_pkg::PC_W-1:0] in_pc;
    logic [gbp_pkg::PC_W-1:0] in_target;
    logic                     in_taken;
    logic [BASE_W-1:0]        in_base;

    assign in_pc     = s_tdata[gbp_pkg::PC_W-1:0];
    assign in_target = s_tdata[2*gbp_pkg::PC_W-1:gbp_pkg::PC_W];
    assign in_taken  = s_tdata[2*gbp_pkg::PC_W];
    assign in_base   = {in_target, in_pc, in_taken, s_tuser};

    generate
        if (IS_POW2) begin : g_mask
            // The buffer index is a plain slice of the word address.
            assign s_tready = q_ready && !busy;
            assign q_valid  = s_tvalid && !busy;
            assign q_data   = {in_pc[BI_W+1:2], in_base};
        end else begin : g_rem
            // The quotient comes from a scaled reciprocal, which is exact for every
            // word address; the remainder is the word address minus quotient times
            // the entry count.
            localparam int WORD_W = gbp_pkg::WORD_W;
            localparam int SHIFT  = WORD_W + BI_W;
            localparam int PROD_W = WORD_W + 32;
            localparam logic [31:0] RECIP =
                32'(((64'd1 << SHIFT) + 64'(BTB_ENTRIES) - 64'd1) / 64'(BTB_ENTRIES));

            gbp_pkg::front_state_t state_reg, state_next;
            logic [BASE_W-1:0]     base_reg, base_next;
            logic [WORD_W-1:0]     div_reg, div_next;
            logic [WORD_W-1:0]     quot_reg, quot_next;
            logic [WORD_W-1:0]     qn_reg, qn_next;
            logic [BI_W-1:0]       rem_reg, rem_next;
            logic [PROD_W-1:0]     prod;

            assign prod = PROD_W'(div_reg) * PROD_W'(RECIP);

            always_comb begin
                state_next = state_reg;
                base_next  = base_reg;
                div_next   = div_reg;
                quot_next  = quot_reg;
                qn_next    = qn_reg;
                rem_next   = rem_reg;
                s_tready   = 1'b0;
                q_valid    = 1'b0;
                unique case (state_reg)
                    gbp_pkg::F_IDLE: begin
                        s_tready = !busy;
                        if (s_tvalid && !busy) begin
                            base_next  = in_base;
                            div_next   = in_pc[gbp_pkg::PC_W-1:2];
                            state_next = gbp_pkg::F_MUL;
                        end
                    end
                    gbp_pkg::F_MUL: begin
                        quot_next  = WORD_W'(prod[PROD_W-1:SHIFT]);
                        state_next = gbp_pkg::F_DIV;
                    end
                    gbp_pkg::F_DIV: begin
                        qn_next    = quot_reg * WORD_W'(BTB_ENTRIES);
                        state_next = gbp_pkg::F_REM;
                    end
                    gbp_pkg::F_REM: begin
                        rem_next   = BI_W'(div_reg - qn_reg);
                        state_next = gbp_pkg::F_PUSH;
                    end
                    gbp_pkg::F_PUSH: begin
                        q_valid = 1'b1;
                        if (q_ready) begin
                            state_next = gbp_pkg::F_IDLE;
                        end
                    end
                    default: begin
                        state_next = gbp_pkg::F_IDLE;
                    end
                endcase
            end

            assign q_data = {rem_reg, base_reg};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    state_reg <= gbp_pkg::F_IDLE;
                end else begin
                    state_reg <= state_next;
                end
            end

            always_ff @(posedge aclk) begin
                base_reg <= base_next;
                div_reg  <= div_next;
                quot_reg <= quot_next;
                qn_reg   <= qn_next;
                rem_reg  <= rem_next;
            end
        end
    endgenerate

endmodule

[src/gbp_back.sv]
`timescale 1ns / 1ps

module gbp_back #(
    parameter int BTB_ENTRIES  = gbp_pkg::DEF_BTB_ENTRIES,
    parameter int HISTORY_BITS = gbp_pkg::DEF_HISTORY_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    output logic                                busy,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic [gbp_pkg::ITEM_BI_LSB+$clog2(BTB_ENTRIES)-1:0] q_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gbp_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int PC_W      = gbp_pkg::PC_W;
    localparam int BI_W      = $clog2(BTB_ENTRIES);
    localparam int TAG_W     = gbp_pkg::WORD_W - BI_W;
    localparam int PHT_DEPTH = 1 << HISTORY_BITS;
    localparam int CLR_DEPTH = (PHT_DEPTH > BTB_ENTRIES) ? PHT_DEPTH : BTB_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int ENTRY_W   = 1 + TAG_W + PC_W;

    gbp_pkg::back_state_t state_reg, state_next;
    logic [CLR_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [HISTORY_BITS-1:0] hist_reg, hist_next;
    logic [HISTORY_BITS:0]   hist_shift;

    logic                    kind_reg, kind_next;
    logic                    taken_reg, taken_next;
    logic [PC_W-1:0]         pc_reg, pc_next;
    logic [PC_W-1:0]         target_reg, target_next;
    logic [BI_W-1:0]         bi_reg, bi_next;
    logic [HISTORY_BITS-1:0] ci_reg, ci_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [PC_W-1:0]         m_next_pc_reg, m_next_pc_next;
    logic                    m_pred_reg, m_pred_next;

    logic [1:0]              pht_mem [PHT_DEPTH];
    logic [1:0]              pht_rd_reg;
    logic                    pht_we, pht_re;
    logic [HISTORY_BITS-1:0] pht_wa;
    logic [1:0]              pht_wd;

    // Each buffer entry holds {valid, tag, target}.
    logic [ENTRY_W-1:0]      btb_mem [BTB_ENTRIES];
    logic [ENTRY_W-1:0]      btb_rd_reg;
    logic                    btb_we, btb_re;
    logic [BI_W-1:0]         btb_wa;
    logic [ENTRY_W-1:0]      btb_wd;

    logic [PC_W-1:0]         q_pc;
    logic                    pred;
    logic                    hit;

    assign q_pc       = q_data[gbp_pkg::ITEM_PC_LSB +: PC_W];
    assign hist_shift = {hist_reg, taken_reg};
    assign pred       = pht_rd_reg[1];
    assign hit        = btb_rd_reg[ENTRY_W-1] &&
                        (btb_rd_reg[PC_W +: TAG_W] == pc_reg[PC_W-1:BI_W+2]);

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        hist_next      = hist_reg;
        kind_next      = kind_reg;
        taken_next     = taken_reg;
        pc_next        = pc_reg;
        target_next    = target_reg;
        bi_next        = bi_reg;
        ci_next        = ci_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_next_pc_next = m_next_pc_reg;
        m_pred_next    = m_pred_reg;
        busy           = 1'b0;
        q_ready        = 1'b0;
        pht_we         = 1'b0;
        pht_re         = 1'b0;
        pht_wa         = ci_reg;
        pht_wd         = pht_rd_reg;
        btb_we         = 1'b0;
        btb_re         = 1'b0;
        btb_wa         = bi_reg;
        btb_wd         = {1'b1, pc_reg[PC_W-1:BI_W+2], target_reg};
        unique case (state_reg)
            gbp_pkg::B_CLEAR: begin
                busy   = 1'b1;
                pht_we = ({1'b0, clr_cnt_reg} < (CLR_W+1)'(PHT_DEPTH));
                pht_wa = clr_cnt_reg[HISTORY_BITS-1:0];
                pht_wd = gbp_pkg::CTR_WEAK_TAKEN;
                btb_we = ({1'b0, clr_cnt_reg} < (CLR_W+1)'(BTB_ENTRIES));
                btb_wa = clr_cnt_reg[BI_W-1:0];
                btb_wd = '0;
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1)) begin
                    state_next = gbp_pkg::B_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            gbp_pkg::B_IDLE: begin
                q_ready = 1'b1;
                ci_next = q_pc[HISTORY_BITS+1:2] ^ hist_reg;
                if (q_valid) begin
                    kind_next   = q_data[gbp_pkg::ITEM_KIND];
                    taken_next  = q_data[gbp_pkg::ITEM_TAKEN];
                    pc_next     = q_pc;
                    target_next = q_data[gbp_pkg::ITEM_TGT_LSB +: PC_W];
                    bi_next     = q_data[gbp_pkg::ITEM_BI_LSB +: BI_W];
                    pht_re      = 1'b1;
                    btb_re      = 1'b1;
                    state_next  = gbp_pkg::B_EXEC;
                end
            end
            gbp_pkg::B_EXEC: begin
                if (kind_reg == gbp_pkg::KIND_PREDICT) begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_next  = 1'b1;
                        m_pred_next    = pred;
                        m_next_pc_next = (pred && hit) ? btb_rd_reg[PC_W-1:0]
                                                       : pc_reg + gbp_pkg::PC_STEP;
                        state_next     = gbp_pkg::B_IDLE;
                    end
                end else begin
                    pht_we = 1'b1;
                    if (taken_reg) begin
                        if (pht_rd_reg != gbp_pkg::CTR_MAX) begin
                            pht_wd = pht_rd_reg + 1'b1;
                        end
                    end else begin
                        if (pht_rd_reg != gbp_pkg::CTR_MIN) begin
                            pht_wd = pht_rd_reg - 1'b1;
                        end
                    end
                    hist_next  = hist_shift[HISTORY_BITS-1:0];
                    btb_we     = taken_reg;
                    state_next = gbp_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = gbp_pkg::B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gbp_pkg::B_CLEAR;
            clr_cnt_reg  <= '0;
            hist_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            hist_reg     <= hist_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        taken_reg     <= taken_next;
        pc_reg        <= pc_next;
        target_reg    <= target_next;
        bi_reg        <= bi_next;
        ci_reg        <= ci_next;
        m_next_pc_reg <= m_next_pc_next;
        m_pred_reg    <= m_pred_next;
    end

    always_ff @(posedge aclk) begin
        if (pht_we) begin
            pht_mem[pht_wa] <= pht_wd;
        end
        if (pht_re) begin
            pht_rd_reg <= pht_mem[ci_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (btb_we) begin
            btb_mem[btb_wa] <= btb_wd;
        end
        if (btb_re) begin
            btb_rd_reg <= btb_mem[bi_next];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_pred_reg, m_next_pc_reg};

endmodule

[src/gshare_branch_predictor_btb.sv]
`timescale 1ns / 1ps

// Gshare branch predictor with a direct-mapped, tagged branch target buffer.
// A transaction with s_tuser low is a prediction request and returns one
// transaction on the m_ side; one with s_tuser high is a resolved-branch update
// and returns nothing. Results come back in request order. The front end takes
// in a transaction and works out its buffer index; a two-entry queue hands it to
// the back end. There B_IDLE takes an item and starts the registered reads of
// the counter table and the target buffer, and B_EXEC forms the prediction or
// writes the update back; the back end takes no new item until it is done with
// the last. When BTB_ENTRIES is not a power of two, the index is a remainder
// computed by a reciprocal multiplication in the F_MUL, F_DIV and F_REM states,
// and the front end takes no new transaction until the last has gone to the
// queue. After reset a clearing pass over max(2**HISTORY_BITS, BTB_ENTRIES)
// addresses sets up both tables; s_tready stays low until it ends.
module gshare_branch_predictor_btb #(
    parameter int BTB_ENTRIES  = gbp_pkg::DEF_BTB_ENTRIES,
    parameter int HISTORY_BITS = gbp_pkg::DEF_HISTORY_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // kind (0 = predict, 1 = update)
    input  logic                          s_tuser,
    // pc [31:0], target [63:32], taken [64], zero fill [71:65]
    input  logic [gbp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_pc [31:0], predicted_taken [32], zero fill [39:33]
    output logic [gbp_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int ITEM_W = gbp_pkg::ITEM_BI_LSB + $clog2(BTB_ENTRIES);

    logic              busy;
    logic              fq_valid, fq_ready;
    logic [ITEM_W-1:0] fq_data;
    logic              qb_valid, qb_ready;
    logic [ITEM_W-1:0] qb_data;

    gbp_front #(
        .BTB_ENTRIES(BTB_ENTRIES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .busy    (busy),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    gbp_queue #(
        .WIDTH(ITEM_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_data  (fq_data),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_data (qb_data)
    );

    gbp_back #(
        .BTB_ENTRIES (BTB_ENTRIES),
        .HISTORY_BITS(HISTORY_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .busy    (busy),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

[tb/sv/tb_gshare_branch_predictor_btb.sv]
`timescale 1ns / 1ps

module tb_gshare_branch_predictor_btb;

    localparam int PC_W         = gbp_pkg::PC_W;
    localparam int WORD_W       = gbp_pkg::WORD_W;
    localparam int NUM_SLOTS    = gbp_pkg::DEF_BTB_ENTRIES;
    localparam int HIST_W       = gbp_pkg::DEF_HISTORY_BITS;
    localparam int CTR_DEPTH    = 1 << HIST_W;
    localparam int TAG_SHIFT    = $clog2(NUM_SLOTS);
    localparam int TAG_W        = WORD_W - TAG_SHIFT;
    localparam int RANDOM_ITEMS = 1700;
    localparam int NUM_DIRECTED = 19;
    localparam int POOL_SIZE    = 16;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            taken;
    } fetch_guess_t;

    typedef struct packed {
        logic            kind;
        logic [PC_W-1:0] pc;
        logic [PC_W-1:0] target;
        logic            taken;
        logic            has_fixed;
        logic [PC_W-1:0] fixed_next_pc;
        logic            fixed_taken;
    } branch_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic                          s_tuser;
    logic [gbp_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [gbp_pkg::M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the predictor state.
    logic [1:0]        ctr_table [CTR_DEPTH];
    logic [HIST_W-1:0] ghist;
    logic              btb_valid [NUM_SLOTS];
    logic [TAG_W-1:0]  btb_tag [NUM_SLOTS];
    logic [PC_W-1:0]   btb_target [NUM_SLOTS];

    fetch_guess_t pending_fetch_q [$];
    int           error_count = 0;
    logic         tx_burst = 1'b0;
    logic         rx_burst = 1'b0;

    gshare_branch_predictor_btb dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic fetch_guess_t predict_fetch(logic [PC_W-1:0] pc);
        logic [WORD_W-1:0] word;
        int                ci;
        int                bi;
        fetch_guess_t      guess;
        word = pc[PC_W-1:2];
        ci = int'(word[HIST_W-1:0] ^ ghist);
        bi = int'(word % NUM_SLOTS);
        guess.taken = (ctr_table[ci] >= gbp_pkg::CTR_WEAK_TAKEN);
        guess.next_pc = pc + gbp_pkg::PC_STEP;
        // The buffer is only consulted when the counter leans toward taken.
        if (guess.taken && btb_valid[bi] && btb_tag[bi] == TAG_W'(word >> TAG_SHIFT)) begin
            guess.next_pc = btb_target[bi];
        end
        return guess;
    endfunction

    function automatic void train_branch(logic [PC_W-1:0] pc, logic [PC_W-1:0] target,
                                         logic taken);
        logic [WORD_W-1:0] word;
        int                ci;
        int                bi;
        word = pc[PC_W-1:2];
        ci = int'(word[HIST_W-1:0] ^ ghist);
        bi = int'(word % NUM_SLOTS);
        if (taken && ctr_table[ci] != gbp_pkg::CTR_MAX) begin
            ctr_table[ci] = ctr_table[ci] + 2'd1;
        end else if (!taken && ctr_table[ci] != gbp_pkg::CTR_MIN) begin
            ctr_table[ci] = ctr_table[ci] - 2'd1;
        end
        ghist = {ghist[HIST_W-2:0], taken};
        if (taken) begin
            btb_valid[bi] = 1'b1;
            btb_tag[bi] = TAG_W'(word >> TAG_SHIFT);
            btb_target[bi] = target;
        end
    endfunction

    // Called just after a falling edge; returns just after the falling edge that
    // follows the accepting rising edge.
    task automatic send_branch_item(branch_row_t row);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser = row.kind;
        s_tdata = '0;
        s_tdata[31:0] = row.pc;
        s_tdata[63:32] = row.target;
        s_tdata[64] = row.taken;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (row.kind == gbp_pkg::KIND_PREDICT) begin
            if (row.has_fixed) begin
                pending_fetch_q.push_back('{row.fixed_next_pc, row.fixed_taken});
            end else begin
                pending_fetch_q.push_back(predict_fetch(row.pc));
            end
        end else begin
            train_branch(row.pc, row.target, row.taken);
        end
        @(negedge aclk);
    endtask

    // Result side: random stalls, one check per accepted transaction.
    initial begin
        m_tready = 1'b0;
        forever begin
            int           stall;
            fetch_guess_t want;
            logic [PC_W-1:0] got_next_pc;
            logic         got_taken;
            if ($urandom_range(0, 39) == 0) begin
                rx_burst = !rx_burst;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got_next_pc = m_tdata[31:0];
            got_taken = m_tdata[32];
            if (pending_fetch_q.size() == 0) begin
                $display("%0t: unexpected result, next_pc=%h predicted_taken=%b",
                         $time, got_next_pc, got_taken);
                error_count++;
            end else begin
                want = pending_fetch_q.pop_front();
                if (got_next_pc !== want.next_pc) begin
                    $display("%0t: next_pc mismatch, expected %h, actual %h",
                             $time, want.next_pc, got_next_pc);
                    error_count++;
                end
                if (got_taken !== want.taken) begin
                    $display("%0t: predicted_taken mismatch, expected %b, actual %b",
                             $time, want.taken, got_taken);
                    error_count++;
                end
            end
            @(negedge aclk);
        end
    end

    initial begin
        branch_row_t     directed [NUM_DIRECTED];
        branch_row_t     row;
        logic [PC_W-1:0] branch_pc [POOL_SIZE];
        logic [PC_W-1:0] branch_tgt [POOL_SIZE];
        int              bias [POOL_SIZE];
        int              sent;
        int              next_refresh;
        int              slot;
        int              drain_cycles;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = gbp_pkg::KIND_PREDICT;
        s_tdata = '0;
        for (int i = 0; i < CTR_DEPTH; i++) begin
            ctr_table[i] = gbp_pkg::CTR_WEAK_TAKEN;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            btb_valid[i] = 1'b0;
            btb_tag[i] = '0;
            btb_target[i] = '0;
        end
        ghist = '0;

        // Right after reset every counter is weakly taken and the buffer is empty,
        // so the first requests fall through to pc + 4, wrapping at the top.
        directed[0]  = '{gbp_pkg::KIND_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 1'b1,
                         32'h0000_0004, 1'b1};
        directed[1]  = '{gbp_pkg::KIND_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 1'b1,
                         32'h0000_0000, 1'b1};
        directed[2]  = '{gbp_pkg::KIND_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1,
                         32'h0000_0003, 1'b1};
        directed[3]  = '{gbp_pkg::KIND_UPDATE,  32'h0000_0100, 32'hFFFF_FFFF, 1'b1, 1'b0,
                         32'h0, 1'b0};
        directed[4]  = '{gbp_pkg::KIND_PREDICT, 32'h0000_0100, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        // Same buffer slot, different tag.
        directed[5]  = '{gbp_pkg::KIND_PREDICT, 32'h0000_0200, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        // Drive the counters toward not taken; the buffer entry must survive.
        directed[6]  = '{gbp_pkg::KIND_UPDATE,  32'h0000_0100, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        directed[7]  = '{gbp_pkg::KIND_UPDATE,  32'h0000_0100, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        directed[8]  = '{gbp_pkg::KIND_UPDATE,  32'h0000_0100, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        directed[9]  = '{gbp_pkg::KIND_PREDICT, 32'h0000_0100, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        directed[10] = '{gbp_pkg::KIND_UPDATE,  32'hFFFF_FFFC, 32'h0, 1'b1, 1'b0,
                         32'h0, 1'b0};
        directed[11] = '{gbp_pkg::KIND_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        directed[12] = '{gbp_pkg::KIND_UPDATE,  32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b0,
                         32'h0, 1'b0};
        directed[13] = '{gbp_pkg::KIND_PREDICT, 32'hFFFF_FFFE, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        directed[14] = '{gbp_pkg::KIND_UPDATE,  32'h0000_0200, 32'hA5A5_A5A4, 1'b1, 1'b0,
                         32'h0, 1'b0};
        directed[15] = '{gbp_pkg::KIND_PREDICT, 32'h0000_0100, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        directed[16] = '{gbp_pkg::KIND_PREDICT, 32'h0000_0200, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        directed[17] = '{gbp_pkg::KIND_UPDATE,  32'h0000_0000, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};
        directed[18] = '{gbp_pkg::KIND_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 1'b0,
                         32'h0, 1'b0};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_branch_item(directed[i]);
        end

        // Mostly predict-then-resolve pairs over a small set of branches, so that
        // counters saturate and buffer entries hit, alias and get replaced.
        sent = 0;
        next_refresh = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_refresh) begin
                for (int i = 0; i < POOL_SIZE; i++) begin
                    if (i > 0 && $urandom_range(0, 3) == 0) begin
                        branch_pc[i] = branch_pc[i-1] + ($urandom_range(1, 7) << 8);
                    end else begin
                        branch_pc[i] = $urandom;
                    end
                    branch_tgt[i] = $urandom;
                    bias[i] = 5 + 45 * $urandom_range(0, 2);
                end
                next_refresh = sent + 400;
            end
            slot = $urandom_range(0, POOL_SIZE - 1);
            row = '0;
            if ($urandom_range(0, 4) != 0) begin
                row.kind = gbp_pkg::KIND_PREDICT;
                row.pc = branch_pc[slot];
                row.target = $urandom;
                send_branch_item(row);
                row.kind = gbp_pkg::KIND_UPDATE;
                row.taken = ($urandom_range(0, 99) < bias[slot]);
                row.target = ($urandom_range(0, 9) == 0) ? $urandom : branch_tgt[slot];
                send_branch_item(row);
                sent += 2;
            end else begin
                row.kind = 1'($urandom_range(0, 1));
                row.pc = $urandom;
                row.target = $urandom;
                row.taken = 1'($urandom_range(0, 1));
                send_branch_item(row);
                sent++;
            end
        end
        s_tvalid = 1'b0;

        drain_cycles = 0;
        while (pending_fetch_q.size() != 0 && drain_cycles < 4000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (20) @(posedge aclk);
        if (pending_fetch_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived, oldest next_pc=%h",
                     $time, pending_fetch_q.size(), pending_fetch_q[0].next_pc);
            error_count++;
        end

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
src/gbp_pkg.sv
src/gbp_queue.sv
src/gbp_front.sv
src/gbp_back.sv
src/gshare_branch_predictor_btb.sv
tb/sv/tb_gshare_branch_predictor_btb.sv
